### rtl/gccr_pkg.sv
package gccr_pkg;

  // Configuration register width and indexes
  localparam int unsigned CFG_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

  // Payload widths
  localparam int unsigned PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

  // Operation codes carried in s_axis_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // Output tuser bits
  typedef struct packed {
    logic not_ready;
    logic image_last;
  } out_user_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVY,
    ST_DIVX,
    ST_STREAM
  } state_e;

endpackage

### rtl/gccr_ram.sv
module gccr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/glyph_crop_center_resize_top.sv
// Load item (tuser 0): written into the frame store unless the frame is full, no output item.
// Emit item (tuser 1): setup (one shared bit-serial divider), then out_width items at
//   one per cycle unless the receiver stalls; a row requested before the frame is full
//   skips the setup.
// After setup each output item is registered in the output stage, its pixel from the frame store read port.
// Reset clears load position, bounding box, row counter and registers to defaults;
//   the frame store is not cleared and reads only entries written in this frame.
module glyph_crop_center_resize_top #(
  parameter int unsigned MAX_SRC_DIM = 64,
  parameter int unsigned MAX_OUT_DIM = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tdata: pixel_in[7:0]
  input  logic [7:0]                   s_axis_tdata,
  // tuser: operation[0]
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: pixel_out[7:0]
  output logic [7:0]                   m_axis_tdata,
  // tuser: image_last[0], not_ready[1]
  output gccr_pkg::out_user_t          m_axis_tuser,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         cfg_we_i,
  input  logic [gccr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gccr_pkg::CFG_W-1:0]   cfg_data_i
);
  import gccr_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_SRC_DIM);
  localparam int unsigned DW    = CW + 1;
  localparam int unsigned OCW   = $clog2(MAX_OUT_DIM);
  localparam int unsigned ODW   = OCW + 1;
  localparam int unsigned DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = OCW + DW;
  localparam int unsigned NW    = $clog2(PW + 1);

  // Configuration registers
  logic [CFG_W-1:0] src_width_q, src_height_q, out_width_q, out_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= CFG_W'(64);
      src_height_q <= CFG_W'(64);
      out_width_q  <= CFG_W'(32);
      out_height_q <= CFG_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i;
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i;
        REG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
        REG_OUT_HEIGHT: out_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp registers into the supported range
  function automatic logic [DW-1:0] clamp_src(input logic [CFG_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (32'(v) > MAX_SRC_DIM) r = DW'(MAX_SRC_DIM);
    else r = DW'(v);
    return r;
  endfunction

  function automatic logic [ODW-1:0] clamp_out(input logic [CFG_W-1:0] v);
    logic [ODW-1:0] r;
    if (v == '0) r = ODW'(1);
    else if (32'(v) > MAX_OUT_DIM) r = ODW'(MAX_OUT_DIM);
    else r = ODW'(v);
    return r;
  endfunction

  logic [DW-1:0]  sw, sh;
  logic [ODW-1:0] ow, oh;

  assign sw = clamp_src(src_width_q);
  assign sh = clamp_src(src_height_q);
  assign ow = clamp_out(out_width_q);
  assign oh = clamp_out(out_height_q);

  // Frame state
  state_e          state_q, state_d;
  logic [DW-1:0]   ld_col_q, ld_col_d, ld_row_q, ld_row_d;
  logic [CW-1:0]   left_q, left_d, right_q, right_d, top_q, top_d, bottom_q, bottom_d;
  logic            found_q, found_d;
  logic [OCW-1:0]  emit_row_q, emit_row_d;

  // Row setup registers
  logic [OCW-1:0]  r_q, r_d;
  logic            last_row_q, last_row_d;
  logic            nr_q, nr_d;
  logic [DW-1:0]   bw_q, bw_d, bh_q, bh_d, side_q, side_d, xo_q, xo_d;
  logic            y_in_q, y_in_d;
  logic [AW-1:0]   row_base_q, row_base_d;
  logic [DW-1:0]   qs_q, qs_d;
  logic [ODW-1:0]  rs_q, rs_d;

  // Divider registers
  logic [ODW:0]    dv_rem_q, dv_rem_d;
  logic [PW-1:0]   dv_quo_q, dv_quo_d;
  logic [ODW-1:0]  dv_div_q, dv_div_d;
  logic [NW-1:0]   dv_cnt_q, dv_cnt_d;

  // Column walk
  logic [ODW-1:0]  col_q, col_d;
  logic [DW-1:0]   sx_q, sx_d;
  logic [ODW-1:0]  rx_q, rx_d;

  // Output stage
  logic            b_valid_q, b_valid_d;
  logic            b_inside_q, b_inside_d;
  logic            b_last_q, b_last_d;
  out_user_t       b_user_q, b_user_d;

  // Frame store ports
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [PIX_W-1:0] mem_rdata;

  gccr_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(s_axis_tdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Load position after a possible wrap when src_width shrank
  logic            ld_wrap, ld_skip, full;
  logic [DW-1:0]   ld_er, ld_ec, ld_nc;

  assign full    = ld_row_q >= sh;
  assign ld_wrap = ld_col_q >= sw;
  assign ld_er   = ld_wrap ? ld_row_q + DW'(1) : ld_row_q;
  assign ld_ec   = ld_wrap ? '0 : ld_col_q;
  assign ld_skip = ld_er >= sh;
  assign ld_nc   = ld_ec + DW'(1);

  // Box geometry from the current box
  logic [DW-1:0]   g_bw, g_bh0, g_bh, g_side;
  logic [DW+1:0]   g_bw3;
  logic [OCW-1:0]  g_r;

  assign g_bw   = DW'(right_q) - DW'(left_q) + DW'(1);
  assign g_bh0  = DW'(bottom_q) - DW'(top_q) + DW'(1);
  assign g_bw3  = (DW+2)'(g_bw) * (DW+2)'(3);
  assign g_bh   = ({g_bh0, 1'b0} >= (DW+1)'(g_bw3)) ? DW'(g_bw3 >> 1) : g_bh0;
  assign g_side = (g_bw > g_bh) ? g_bw : g_bh;
  assign g_r    = (ODW'(emit_row_q) >= oh) ? OCW'(oh - ODW'(1)) : emit_row_q;

  // Divider step
  logic [ODW:0]    dv_sh;
  logic            dv_ge;
  logic [DW-1:0]   sy, yo;

  assign dv_sh = {dv_rem_q[ODW-1:0], dv_quo_q[PW-1]};
  assign dv_ge = dv_sh >= {1'b0, dv_div_q};
  assign sy    = DW'(dv_quo_q);
  assign yo    = (side_q - bh_q) >> 1;

  // Column position of the item in flight
  logic            a_active, a_adv, x_in;
  logic [DW-1:0]   a_col;
  logic [ODW:0]    rx_sum;

  assign a_active = (state_q == ST_STREAM) && (col_q < ow);
  assign a_adv    = a_active && (!b_valid_q || m_axis_tready);
  assign x_in     = (sx_q >= xo_q) && (sx_q < xo_q + bw_q);
  assign a_col    = DW'(left_q) + sx_q - xo_q;
  assign rx_sum   = (ODW+1)'(rx_q) + (ODW+1)'(rs_q);

  assign mem_re    = a_adv;
  assign mem_raddr = row_base_q + AW'(a_col[CW-1:0]);

  assign s_axis_tready = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    ld_col_d   = ld_col_q;
    ld_row_d   = ld_row_q;
    left_d     = left_q;
    right_d    = right_q;
    top_d      = top_q;
    bottom_d   = bottom_q;
    found_d    = found_q;
    emit_row_d = emit_row_q;
    r_d        = r_q;
    last_row_d = last_row_q;
    nr_d       = nr_q;
    bw_d       = bw_q;
    bh_d       = bh_q;
    side_d     = side_q;
    xo_d       = xo_q;
    y_in_d     = y_in_q;
    row_base_d = row_base_q;
    qs_d       = qs_q;
    rs_d       = rs_q;
    dv_rem_d   = dv_rem_q;
    dv_quo_d   = dv_quo_q;
    dv_div_d   = dv_div_q;
    dv_cnt_d   = dv_cnt_q;
    col_d      = col_q;
    sx_d       = sx_q;
    rx_d       = rx_q;
    b_valid_d  = b_valid_q;
    b_inside_d = b_inside_q;
    b_last_d   = b_last_q;
    b_user_d   = b_user_q;
    mem_we     = 1'b0;
    mem_waddr  = AW'(ld_er[CW-1:0]) * AW'(MAX_SRC_DIM) + AW'(ld_ec[CW-1:0]);

    // Drop the output item once taken
    if (m_axis_tready) begin
      b_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == OP_LOAD) begin
            if (!full) begin
              if (ld_skip) begin
                ld_col_d = '0;
                ld_row_d = ld_er;
              end else begin
                mem_we = 1'b1;
                if (s_axis_tdata != PIX_WHITE) begin
                  if (!found_q) begin
                    found_d  = 1'b1;
                    left_d   = ld_ec[CW-1:0];
                    right_d  = ld_ec[CW-1:0];
                    top_d    = ld_er[CW-1:0];
                    bottom_d = ld_er[CW-1:0];
                  end else begin
                    if (ld_ec[CW-1:0] < left_q)  left_d  = ld_ec[CW-1:0];
                    if (ld_ec[CW-1:0] > right_q) right_d = ld_ec[CW-1:0];
                    bottom_d = ld_er[CW-1:0];
                  end
                end
                if (ld_nc >= sw) begin
                  ld_col_d = '0;
                  ld_row_d = ld_er + DW'(1);
                end else begin
                  ld_col_d = ld_nc;
                  ld_row_d = ld_er;
                end
              end
            end
          end else if (!full) begin
            // Row requested early: white row flagged not ready
            nr_d       = 1'b1;
            last_row_d = 1'b0;
            col_d      = '0;
            state_d    = ST_STREAM;
          end else begin
            nr_d       = 1'b0;
            r_d        = g_r;
            last_row_d = (ODW'(g_r) + ODW'(1)) == oh;
            bw_d       = g_bw;
            bh_d       = g_bh;
            side_d     = g_side;
            xo_d       = (g_side - g_bw) >> 1;
            state_d    = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        // Start sy = r*side/oh
        dv_rem_d = '0;
        dv_quo_d = PW'(r_q) * PW'(side_q);
        dv_div_d = oh;
        dv_cnt_d = NW'(PW);
        state_d  = ST_DIVY;
      end

      ST_DIVY, ST_DIVX: begin
        if (dv_cnt_q != '0) begin
          dv_rem_d = dv_ge ? dv_sh - {1'b0, dv_div_q} : dv_sh;
          dv_quo_d = {dv_quo_q[PW-2:0], dv_ge};
          dv_cnt_d = dv_cnt_q - NW'(1);
        end else if (state_q == ST_DIVY) begin
          y_in_d     = (sy >= yo) && (sy < yo + bh_q);
          row_base_d = AW'(DW'(top_q) + sy - yo) * AW'(MAX_SRC_DIM);
          // Start side/ow for the column step
          dv_rem_d   = '0;
          dv_quo_d   = PW'(side_q);
          dv_div_d   = ow;
          dv_cnt_d   = NW'(PW);
          state_d    = ST_DIVX;
        end else begin
          qs_d    = DW'(dv_quo_q);
          rs_d    = dv_rem_q[ODW-1:0];
          col_d   = '0;
          sx_d    = '0;
          rx_d    = '0;
          state_d = ST_STREAM;
        end
      end

      ST_STREAM: begin
        if (a_adv) begin
          b_valid_d           = 1'b1;
          b_inside_d          = !nr_q && found_q && y_in_q && x_in;
          b_last_d            = (col_q + ODW'(1)) == ow;
          b_user_d.not_ready  = nr_q;
          b_user_d.image_last = !nr_q && last_row_q && ((col_q + ODW'(1)) == ow);
          col_d               = col_q + ODW'(1);
          // Advance sx by side/ow with remainder carry
          if (rx_sum >= (ODW+1)'(ow)) begin
            rx_d = ODW'(rx_sum - (ODW+1)'(ow));
            sx_d = sx_q + qs_q + DW'(1);
          end else begin
            rx_d = ODW'(rx_sum);
            sx_d = sx_q + qs_q;
          end
          if ((col_q + ODW'(1)) == ow) begin
            state_d = ST_IDLE;
            if (!nr_q) begin
              if (last_row_q) begin
                ld_col_d   = '0;
                ld_row_d   = '0;
                left_d     = '0;
                right_d    = '0;
                top_d      = '0;
                bottom_d   = '0;
                found_d    = 1'b0;
                emit_row_d = '0;
              end else begin
                emit_row_d = r_q + OCW'(1);
              end
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ld_col_q   <= '0;
      ld_row_q   <= '0;
      left_q     <= '0;
      right_q    <= '0;
      top_q      <= '0;
      bottom_q   <= '0;
      found_q    <= 1'b0;
      emit_row_q <= '0;
      dv_cnt_q   <= '0;
      col_q      <= '0;
      b_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ld_col_q   <= ld_col_d;
      ld_row_q   <= ld_row_d;
      left_q     <= left_d;
      right_q    <= right_d;
      top_q      <= top_d;
      bottom_q   <= bottom_d;
      found_q    <= found_d;
      emit_row_q <= emit_row_d;
      dv_cnt_q   <= dv_cnt_d;
      col_q      <= col_d;
      b_valid_q  <= b_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    last_row_q <= last_row_d;
    nr_q       <= nr_d;
    bw_q       <= bw_d;
    bh_q       <= bh_d;
    side_q     <= side_d;
    xo_q       <= xo_d;
    y_in_q     <= y_in_d;
    row_base_q <= row_base_d;
    qs_q       <= qs_d;
    rs_q       <= rs_d;
    dv_rem_q   <= dv_rem_d;
    dv_quo_q   <= dv_quo_d;
    dv_div_q   <= dv_div_d;
    sx_q       <= sx_d;
    rx_q       <= rx_d;
    b_inside_q <= b_inside_d;
    b_last_q   <= b_last_d;
    b_user_q   <= b_user_d;
  end

  // Output item
  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tdata  = b_inside_q ? mem_rdata : PIX_WHITE;
  assign m_axis_tlast  = b_last_q;
  assign m_axis_tuser  = b_user_q;

endmodule

### verif/tb_top.sv
module tb_top;
  import gccr_pkg::*;

  // Expected output pixel with its markers
  typedef struct {
    logic [7:0] pix;
    logic       row_last;
    logic       image_last;
    logic       not_ready;
  } out_pix_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [1:0]      idx;
    logic [6:0]      val;
    logic            op;
    logic [7:0]      pix;
    bit              typed;
    logic [7:0]      t_pix;
    logic            t_nr;
  } dir_row_t;

  localparam int SETTLE_CYC   = 40;
  localparam int WDOG_LIMIT   = 5000;
  localparam int HOLD_CYC     = 150;
  localparam int N_DIR        = 25;
  localparam int RAND_ITEMS   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = OP_LOAD;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  out_user_t   m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  glyph_crop_center_resize_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Glyph model state
  logic [7:0]  glyph_mem [4096];
  int unsigned reg_sw, reg_sh, reg_ow, reg_oh;
  int unsigned ld_col, ld_row, bx_l, bx_r, bx_t, bx_b, emit_idx;
  bit          bx_found;
  out_pix_t    pix_expected [$];

  int          err_cnt = 0;
  int          idle_cyc = 0;
  int          hold_left = 0;
  int          rcv_wait = 0;
  bit          no_idle = 0;
  int          items_sent = 0;

  function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    ld_col = 0; ld_row = 0;
    bx_l = 0; bx_r = 0; bx_t = 0; bx_b = 0;
    bx_found = 0; emit_idx = 0;
  endfunction

  function automatic void write_reg(logic [1:0] idx, int unsigned v);
    case (idx)
      REG_SRC_WIDTH:  reg_sw = v;
      REG_SRC_HEIGHT: reg_sh = v;
      REG_OUT_WIDTH:  reg_ow = v;
      default:        reg_oh = v;
    endcase
  endfunction

  // Advance the glyph model by one accepted item and queue its output pixels
  function automatic void crop_resize_step(logic op, logic [7:0] pix);
    int unsigned sw, sh, ow, oh, r, bw, bh, side, xo, yo, sy, sx, c;
    bit full, last_row, skip;
    out_pix_t e;
    sw = eff_dim(reg_sw, 64); sh = eff_dim(reg_sh, 64);
    ow = eff_dim(reg_ow, 64); oh = eff_dim(reg_oh, 64);
    full = (ld_row >= sh);
    skip = 0;
    if (op == OP_LOAD) begin
      if (full) return;
      if (ld_col >= sw) begin
        ld_col = 0;
        ld_row++;
        if (ld_row >= sh) return;
      end
      glyph_mem[ld_row*64 + ld_col] = pix;
      if (pix != 8'hFF) begin
        if (!bx_found) begin
          bx_found = 1;
          bx_l = ld_col; bx_r = ld_col; bx_t = ld_row; bx_b = ld_row;
        end else begin
          if (ld_col < bx_l) bx_l = ld_col;
          if (ld_col > bx_r) bx_r = ld_col;
          bx_b = ld_row;
        end
      end
      ld_col++;
      if (ld_col >= sw) begin
        ld_col = 0;
        ld_row++;
      end
      return;
    end
    if (!full) begin
      for (c = 0; c < ow; c++) begin
        e.pix = 8'hFF; e.row_last = (c + 1 == ow); e.image_last = 0; e.not_ready = 1;
        pix_expected.push_back(e);
      end
      return;
    end
    r = (emit_idx >= oh) ? oh - 1 : emit_idx;
    last_row = (r + 1 == oh);
    bw = bx_r - bx_l + 1;
    bh = bx_b - bx_t + 1;
    if (2*bh >= 3*bw) bh = (3*bw) >> 1;
    side = (bw > bh) ? bw : bh;
    xo = (side - bw) >> 1;
    yo = (side - bh) >> 1;
    sy = (r * side) / oh;
    for (c = 0; c < ow; c++) begin
      sx = (c * side) / ow;
      e.pix = 8'hFF;
      if (bx_found && sx >= xo && sx < xo + bw && sy >= yo && sy < yo + bh)
        e.pix = glyph_mem[(bx_t + sy - yo)*64 + bx_l + sx - xo];
      e.row_last = (c + 1 == ow);
      e.image_last = last_row && (c + 1 == ow);
      e.not_ready = 0;
      pix_expected.push_back(e);
    end
    if (last_row) restart_frame();
    else emit_idx = r + 1;
  endfunction

  // Offer one item after a random gap; predict once it is taken
  task automatic send_item(logic op, logic [7:0] pix);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = pix;
    do @(posedge clk_i); while (!s_axis_tready);
    crop_resize_step(op, pix);
    items_sent++;
  endtask

  // Wait for every expected pixel, then let the block finish its own work
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pix_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    write_reg(idx, 32'(v));
  endtask

  // Load one frame with a random dark region (sometimes blank), then read out every row
  task automatic run_frame(int unsigned sw_raw, int unsigned sh_raw,
                           int unsigned ow_raw, int unsigned oh_raw, bit stall);
    int unsigned sw, sh, oh, x0, x1, y0, y1, x, y, k;
    bit blank;
    logic [7:0] p;
    drain();
    cfg_write(REG_SRC_WIDTH, 7'(sw_raw));
    cfg_write(REG_SRC_HEIGHT, 7'(sh_raw));
    cfg_write(REG_OUT_WIDTH, 7'(ow_raw));
    cfg_write(REG_OUT_HEIGHT, 7'(oh_raw));
    sw = eff_dim(sw_raw, 64); sh = eff_dim(sh_raw, 64); oh = eff_dim(oh_raw, 64);
    x0 = $urandom_range(0, sw - 1); x1 = $urandom_range(x0, sw - 1);
    y0 = $urandom_range(0, sh - 1); y1 = $urandom_range(y0, sh - 1);
    blank = ($urandom_range(0, 7) == 0);
    no_idle = ($urandom_range(0, 3) == 0);
    for (y = 0; y < sh; y++) begin
      for (x = 0; x < sw; x++) begin
        p = 8'hFF;
        if (!blank && x >= x0 && x <= x1 && y >= y0 && y <= y1 && $urandom_range(0, 3) != 0)
          p = 8'($urandom_range(0, 254));
        // occasionally ask for a row too early
        if ($urandom_range(0, 40) == 0) send_item(OP_EMIT, 8'($urandom));
        send_item(OP_LOAD, p);
      end
    end
    // stray loads into a full frame are dropped
    if ($urandom_range(0, 2) == 0) send_item(OP_LOAD, 8'($urandom));
    if (stall) hold_left = HOLD_CYC;
    for (k = 0; k < oh; k++) send_item(OP_EMIT, 8'($urandom));
    no_idle = 0;
  endtask

  // Receiver: long hold-off on request, else random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (rcv_wait > 0) begin
      m_axis_tready <= 1'b0;
      rcv_wait <= rcv_wait - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output item with the oldest expectation
  always @(posedge clk_i) begin
    out_pix_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rcv_wait <= no_idle ? 0 : $urandom_range(0, 3);
      if (pix_expected.size() == 0) begin
        $error("unexpected output item: pixel_out %0d", m_axis_tdata);
        err_cnt++;
      end else begin
        e = pix_expected.pop_front();
        if (m_axis_tdata !== e.pix) begin
          $error("pixel_out: expected %0d, actual %0d", e.pix, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== e.row_last) begin
          $error("row_last: expected %0d, actual %0d", e.row_last, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tuser.image_last !== e.image_last) begin
          $error("image_last: expected %0d, actual %0d", e.image_last,
                 m_axis_tuser.image_last);
          err_cnt++;
        end
        if (m_axis_tuser.not_ready !== e.not_ready) begin
          $error("not_ready: expected %0d, actual %0d", e.not_ready,
                 m_axis_tuser.not_ready);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("glyph_crop_center_resize_top regression: fail");
      $finish;
    end
  end

  dir_row_t dir_tab [N_DIR];

  initial begin
    int i, k, nq;
    // directed rows; typed ones carry the obvious expected pixel and flag
    dir_tab = '{
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_EMIT, 8'd0,   1, 8'hFF, 1'b1},
      '{ROW_CFG,  REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_CFG,  REG_SRC_HEIGHT, 7'd2,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_CFG,  REG_OUT_WIDTH,  7'd3,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_CFG,  REG_OUT_HEIGHT, 7'd2,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'd128, 0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_EMIT, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_CFG,  REG_OUT_HEIGHT, 7'd1,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_EMIT, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_CFG,  REG_SRC_WIDTH,  7'd2,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_CFG,  REG_SRC_HEIGHT, 7'd1,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_EMIT, 8'd0,   1, 8'hFF, 1'b0},
      '{ROW_CFG,  REG_SRC_HEIGHT, 7'd3,   OP_LOAD, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'd1,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'd254, 0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'd3,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_LOAD, 8'hFF,  0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_EMIT, 8'd0,   0, 8'd0,  1'b0},
      '{ROW_ITEM, REG_SRC_WIDTH,  7'd0,   OP_EMIT, 8'd0,   0, 8'd0,  1'b0}
    };
    restart_frame();
    reg_sw = 64; reg_sh = 64; reg_ow = 32; reg_oh = 32;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        nq = pix_expected.size();
        send_item(dir_tab[i].op, dir_tab[i].pix);
        if (dir_tab[i].typed) begin
          for (k = nq; k < pix_expected.size(); k++) begin
            pix_expected[k].pix = dir_tab[i].t_pix;
            pix_expected[k].not_ready = dir_tab[i].t_nr;
          end
        end
      end
    end

    // random frames: extremes first, then small sizes
    run_frame(127, 1, 127, 0, 1);
    run_frame(1, 64, 2, 64, 0);
    run_frame(0, 127, 1, 1, 0);
    while (items_sent < RAND_ITEMS)
      run_frame($urandom_range(1, 8), $urandom_range(1, 8),
                $urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(0, 5) == 0);

    drain();
    if (err_cnt == 0)
      $display("glyph_crop_center_resize_top regression: pass");
    else
      $display("glyph_crop_center_resize_top regression: fail");
    $finish;
  end

endmodule
